// File: src/foc_pkg.sv
package foc_pkg;

  // Fixed widths of the word fields.
  localparam int LOCUS_W = 10;
  localparam int RANK_W = 10;
  localparam int LOCUS_SPAN = 1 << LOCUS_W;

  // The order_slot field is one bit wide, so at most this many orders can be loaded.
  localparam int SLOT_COUNT = 2;

  // Packed stream widths.
  localparam int IN_DATA_W = 24;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_W = 2;

  // Word kinds carried in tuser.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_MAP = 1'b1;

  // Seen-count codes of one order.
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE = 2'd1;
  localparam logic [1:0] SEEN_PAIR = 2'd2;

  // One rank table entry: a valid flag and the rank of the locus in its order.
  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
  } rank_entry_t;

  // Control from the check stage to one order lane.
  typedef struct packed {
    logic step;   // this map word hits a locus of the lane's order
    logic clear;  // the map ends with this word, so the lane state restarts
  } lane_ctrl_t;

endpackage

// File: src/foc_rank_mem.sv
module foc_rank_mem
  import foc_pkg::*;
#(
  parameter int LANES = 2,
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [LANES-1:0]        wr_en,
  input  logic [IDX_W-1:0]        wr_addr,
  input  rank_entry_t             wr_data,
  input  logic                    rd_en,
  input  logic [IDX_W-1:0]        rd_addr,
  output rank_entry_t [LANES-1:0] rd_data,
  output logic                    clearing
);

  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(DEPTH - 1);

  logic [IDX_W-1:0] clr_addr;

  // After reset every entry is swept to "not in order", one address per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    rank_entry_t mem [DEPTH];

    always_ff @(posedge clk) begin
      if (clearing) begin
        mem[clr_addr] <= '0;
      end else if (wr_en[l]) begin
        mem[wr_addr] <= wr_data;
      end
    end

    always_ff @(posedge clk) begin
      if (rd_en) begin
        rd_data[l] <= mem[rd_addr];
      end
    end
  end

endmodule

// File: src/foc_lane_check.sv
module foc_lane_check
  import foc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  lane_ctrl_t        ctrl,
  input  logic [RANK_W-1:0] rank,
  output logic              conflict
);

  logic [1:0]        seen;
  logic [RANK_W-1:0] prev_rank;
  logic              descending;

  assign conflict = ctrl.step && (seen == SEEN_PAIR) &&
                    (descending ? (rank > prev_rank) : (rank < prev_rank));

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      seen       <= SEEN_NONE;
      prev_rank  <= '0;
      descending <= 1'b0;
    end else if (ctrl.step) begin
      prev_rank <= rank;
      case (seen)
        SEEN_NONE: seen <= SEEN_ONE;
        SEEN_ONE: begin
          descending <= rank < prev_rank;
          seen       <= SEEN_PAIR;
        end
        default: seen <= SEEN_PAIR;
      endcase
    end
  end

  // The count saturates at a pair and never reaches the unused code.
  a_seen_saturates: assert property (@(posedge clk) disable iff (rst)
    seen != 2'd3)
    else $error("lane seen count left its range");

endmodule

// File: src/fixed_order_consistency_check_top.sv
// Channel  Direction  Handshake              Payload
// s        in         s_tvalid / s_tready    s_tdata, s_tuser, s_tlast: load or map word
// m        out        m_tvalid / m_tready    m_tdata: verdict of one map
// cfg      in         cfg_valid / cfg_ready  cfg_data: orders_in_use
//
// One word is taken per cycle while s_tready is high. A map word reads the rank table at
// the accept edge and is checked against the per-order state in the check stage; the
// verdict is registered in the output register. After reset the rank table is swept
// clear, one locus per cycle over DEPTH entries (NUM_LOCI, at most 1024), and s_tready
// stays low meanwhile; configuration writes are taken throughout. A verdict waiting in the
// output register holds the next map's last word in the check stage, and s_tready drops.
module fixed_order_consistency_check_top
  import foc_pkg::*;
#(
  parameter int NUM_LOCI = 1024,
  parameter int MAX_ORDERS = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // locus [9:0], rank [19:10], zeros above
  input  logic [IN_USER_W-1:0]  s_tuser,   // kind [0], order_slot [1]
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // consistent [0], zeros above
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  // Only the slots the one-bit order_slot field can address are ever stored.
  localparam int LANES = (MAX_ORDERS < SLOT_COUNT) ? MAX_ORDERS : SLOT_COUNT;
  // Loci above the ten-bit field can never arrive, so the table stops there.
  localparam int DEPTH = (NUM_LOCI < LOCUS_SPAN) ? NUM_LOCI : LOCUS_SPAN;
  localparam int IDX_W = $clog2(DEPTH);

  // Unpacked input fields.
  logic              in_kind;
  logic              in_slot;
  logic [LOCUS_W-1:0] in_locus;
  logic [RANK_W-1:0] in_rank;
  logic              in_range;
  logic              accept;

  assign in_kind  = s_tuser[0];
  assign in_slot  = s_tuser[1];
  assign in_locus = s_tdata[LOCUS_W-1:0];
  assign in_rank  = s_tdata[LOCUS_W+RANK_W-1:LOCUS_W];
  assign in_range = int'(in_locus) < NUM_LOCI;
  assign accept   = s_tvalid && s_tready;

  // Configuration register. Writes are taken at any time.
  logic [CFG_W-1:0] orders_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      orders_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      orders_in_use <= cfg_data;
    end
  end

  // Rank table. Loads write at the accept edge and map words read at the accept edge, so
  // a map word right behind a load of the same locus already sees the new entry.
  logic [LANES-1:0]        wr_en;
  rank_entry_t             wr_entry;
  rank_entry_t [LANES-1:0] rd_entry;
  logic                    clearing;

  assign wr_entry.valid = 1'b1;
  assign wr_entry.rank  = in_rank;

  for (genvar l = 0; l < LANES; l++) begin : g_wr
    assign wr_en[l] = accept && (in_kind == KIND_LOAD) && in_range && (int'(in_slot) == l);
  end

  foc_rank_mem #(
    .LANES(LANES),
    .DEPTH(DEPTH),
    .IDX_W(IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (in_locus[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (accept && (in_kind == KIND_MAP)),
    .rd_addr (in_locus[IDX_W-1:0]),
    .rd_data (rd_entry),
    .clearing(clearing)
  );

  // Check stage: the word whose table read is now available.
  logic s1_valid;
  logic s1_map;
  logic s1_last;
  logic s1_range;
  logic s1_end;
  logic advance;

  // A map's last word may only leave the check stage if the output register is empty or its verdict is taken.
  assign s1_end   = s1_valid && s1_map && s1_last;
  assign advance  = s1_valid && !(s1_end && m_tvalid && !m_tready);
  assign s_tready = !clearing && !(s1_valid && !advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_map   <= in_kind == KIND_MAP;
      s1_last  <= s_tlast;
      s1_range <= in_range;
    end
  end

  // One lane per stored order keeps its direction and last rank.
  logic [LANES-1:0] lane_conflict;
  lane_ctrl_t       lane_ctrl [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign lane_ctrl[l].step  = advance && s1_map && s1_range && rd_entry[l].valid &&
                                (l < int'(orders_in_use));
    assign lane_ctrl[l].clear = advance && s1_end;

    foc_lane_check u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lane_ctrl[l]),
      .rank    (rd_entry[l].rank),
      .conflict(lane_conflict[l])
    );
  end

  // Conflict of the current map, and the verdict register.
  logic conflict_flag;
  logic conflict_now;

  assign conflict_now = conflict_flag || (|lane_conflict);

  always_ff @(posedge clk) begin
    if (rst) begin
      conflict_flag <= 1'b0;
    end else if (advance && s1_map) begin
      conflict_flag <= s1_last ? 1'b0 : conflict_now;
    end
  end

  logic consistent;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && s1_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_end) begin
      consistent <= (orders_in_use == '0) || !conflict_now;
    end
  end

  assign m_tdata = {{(OUT_DATA_W-1){1'b0}}, consistent};

  // A blocked last word keeps its table read for the cycle it is finally checked.
  a_hold_keeps_read: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(rd_entry)))
    else $error("check stage lost its table read while stalled");

  // A fresh verdict comes only from a map's last word leaving the check stage.
  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid) && !$past(rst)) |-> $past(advance && s1_end))
    else $error("verdict without a finished map");

  // No word is taken while the table sweep runs.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("word taken during the table sweep");

  // The check stage and the output register are empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !s1_valid && !m_tvalid)
    else $error("pipeline not empty after reset");

endmodule
